// File: rtl/svpwm_pkg.sv
// Shared widths, constants, register map, sector codes and the sideband type
// of the SVPWM duty calculator. Depends on nothing; every other file uses it.
`timescale 1ns / 1ps

package svpwm_pkg;

  // Field widths.
  localparam int PeriodW = 15;
  localparam int VdcW    = 15;
  localparam int VoltW   = 16;
  localparam int CmpW    = 16;
  localparam int SecW    = 3;
  localparam int FracW   = 15;

  // Configuration port.
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;
  localparam int RegIdxW  = 1;
  localparam logic [RegIdxW-1:0] RegPwmPeriod = 1'b0;
  localparam logic [PeriodW-1:0] PeriodReset  = 15'h7FFF;

  // Q15 constants.
  localparam logic [15:0] Sqrt3Q15     = 16'd56756;
  localparam logic [14:0] HalfSqrt3Q15 = 15'd28378;

  // Internal widths: numerator of the scale factor, alpha product, Y/Z
  // projections, active vector products, selected times and compare sums.
  localparam int NumW  = 31;
  localparam int ProdW = 32;
  localparam int YW    = 17;
  localparam int MulW  = 49;
  localparam int TW    = 50;
  localparam int T0W   = 52;

  // Sector codes: bit0 beta > 0, bit1 Y > 0, bit2 Z > 0.
  localparam logic [SecW-1:0] SecNone    = 3'd0;
  localparam logic [SecW-1:0] SecBeta    = 3'd1;
  localparam logic [SecW-1:0] SecY       = 3'd2;
  localparam logic [SecW-1:0] SecBetaY   = 3'd3;
  localparam logic [SecW-1:0] SecZ       = 3'd4;
  localparam logic [SecW-1:0] SecBetaZ   = 3'd5;
  localparam logic [SecW-1:0] SecYZ      = 3'd6;
  localparam logic [SecW-1:0] SecInvalid = 3'd7;

  // Values that ride along the divider pipeline beside the quotient.
  typedef struct packed {
    logic [SecW-1:0]         sec;
    logic signed [YW-1:0]    ya;
    logic signed [YW-1:0]    za;
    logic signed [VoltW-1:0] be;
  } side_t;

endpackage

// File: rtl/svpwm_in_if.sv
// Input channel of the SVPWM duty calculator: valid/ready plus one voltage vector.
// Depends on svpwm_pkg for the field widths.
`timescale 1ns / 1ps

interface svpwm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [svpwm_pkg::VdcW-1:0]               bus_voltage;
  logic signed [svpwm_pkg::VoltW-1:0]       volt_alpha;
  logic signed [svpwm_pkg::VoltW-1:0]       volt_beta;

  modport source (output valid, bus_voltage, volt_alpha, volt_beta, input ready);
  modport sink   (input valid, bus_voltage, volt_alpha, volt_beta, output ready);
endinterface

// File: rtl/svpwm_out_if.sv
// Output channel of the SVPWM duty calculator: valid/ready plus compare values.
// Depends on svpwm_pkg for the field widths.
`timescale 1ns / 1ps

interface svpwm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svpwm_pkg::CmpW-1:0]   cmp_phase_a;
  logic signed [svpwm_pkg::CmpW-1:0]   cmp_phase_b;
  logic signed [svpwm_pkg::CmpW-1:0]   cmp_phase_c;
  logic [svpwm_pkg::SecW-1:0]          sector_code;
  logic                                clipped;

  modport source (output valid, cmp_phase_a, cmp_phase_b, cmp_phase_c, sector_code,
                  clipped, input ready);
  modport sink   (input valid, cmp_phase_a, cmp_phase_b, cmp_phase_c, sector_code,
                  clipped, output ready);
endinterface

// File: rtl/svpwm_duty_calculator.sv
// SVPWM seven-segment duty calculator, top level: front stage, divider, back stages.
// Depends on svpwm_pkg, svpwm_in_if, svpwm_out_if and svpwm_div.
//
// Usage: each beat on vec_i carries one alpha/beta voltage reference and the DC
// bus voltage; each beat on res_o carries the three phase compare values, the
// sector code and a flag that is set when a compare value was saturated.
// The PWM period is the only register, at byte address 0 of the APB port;
// write it only while no vector is in flight.
// Pipeline: each vector passes through one front stage, 31 divider stages (one
// quotient bit of sqrt3*period/bus voltage each), four multiply/select/add
// stages and the output register; the divider pipeline sets the latency.
// Throughput: one vector per cycle while the skid register is empty.
// Reset empties the pipeline and the output side and sets the period to 32767.
// When res_o stalls, one further beat lands in a skid register and vec_i.ready
// drops in the next cycle, freezing the whole pipeline until the receiver takes
// the held beat; nothing is lost or repeated.
`timescale 1ns / 1ps

module svpwm_duty_calculator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [svpwm_pkg::ApbAddrW-1:0]     paddr,
  input  logic [svpwm_pkg::ApbDataW-1:0]     pwdata,
  output logic [svpwm_pkg::ApbDataW-1:0]     prdata,
  output logic                               pready,
  svpwm_in_if.sink                           vec_i,
  svpwm_out_if.source                        res_o
);

  localparam int PW    = svpwm_pkg::PeriodW;
  localparam int NumW  = svpwm_pkg::NumW;
  localparam int ProdW = svpwm_pkg::ProdW;
  localparam int YW    = svpwm_pkg::YW;
  localparam int MulW  = svpwm_pkg::MulW;
  localparam int TW    = svpwm_pkg::TW;
  localparam int T0W   = svpwm_pkg::T0W;
  localparam int CmpW  = svpwm_pkg::CmpW;
  localparam int SecW  = svpwm_pkg::SecW;
  localparam int FracW = svpwm_pkg::FracW;

  localparam logic signed [T0W-1:0] CmpMax = T0W'(2**(CmpW-1) - 1);
  localparam logic signed [T0W-1:0] CmpMin = -CmpMax - T0W'(1);

  typedef struct packed {
    logic signed [CmpW-1:0] a;
    logic signed [CmpW-1:0] b;
    logic signed [CmpW-1:0] c;
    logic [SecW-1:0]        sec;
    logic                   clip;
  } res_t;

  // Shift out the Q15 fraction and saturate; the top bit flags a clip.
  function automatic logic [CmpW:0] sat_cmp(input logic signed [T0W-1:0] p);
    logic signed [T0W-1:0] q;
    q = p >>> FracW;
    if (q > CmpMax) begin
      return {1'b1, CmpMax[CmpW-1:0]};
    end else if (q < CmpMin) begin
      return {1'b1, CmpMin[CmpW-1:0]};
    end
    return {1'b0, q[CmpW-1:0]};
  endfunction

  // ---------------------------------------------------------------- config
  logic [PW-1:0] period_q;
  logic          reg_hit;

  assign reg_hit = paddr[svpwm_pkg::ApbAddrW-1:2] == svpwm_pkg::RegPwmPeriod;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? svpwm_pkg::ApbDataW'(period_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= svpwm_pkg::PeriodReset;
    end else if (psel && penable && pwrite && reg_hit) begin
      period_q <= pwdata[PW-1:0];
    end
  end

  // ---------------------------------------------------------------- control
  logic en;
  logic skid_v_q;
  logic out_v_q;

  // The pipeline moves as one while the skid register is empty.
  assign en          = !skid_v_q;
  assign vec_i.ready = en;

  // ---------------------------------------------------------------- front stage
  logic                        s0_v_q;
  logic [NumW-1:0]             s0_num_q;
  logic signed [ProdW-1:0]     s0_p_q;
  logic signed [CmpW-1:0]      s0_be_q;
  logic [svpwm_pkg::VdcW-1:0]  s0_vdc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= vec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_num_q <= NumW'(svpwm_pkg::Sqrt3Q15) * NumW'(period_q);
      s0_p_q   <= ProdW'($signed({1'b0, svpwm_pkg::HalfSqrt3Q15})) * ProdW'(vec_i.volt_alpha);
      s0_be_q  <= vec_i.volt_beta;
      // A zero bus voltage divides as one.
      s0_vdc_q <= (vec_i.bus_voltage == '0) ? svpwm_pkg::VdcW'(1) : vec_i.bus_voltage;
    end
  end

  // Sign tests and Y/Z projections feed the divider sideband.
  logic signed [ProdW-1:0] be_sh;
  logic signed [ProdW-1:0] p_neg;
  logic signed [ProdW-1:0] y_test;
  logic signed [ProdW-1:0] z_test;
  svpwm_pkg::side_t        side_in;

  always_comb begin
    be_sh       = ProdW'(s0_be_q) <<< 14;
    p_neg       = -s0_p_q;
    y_test      = s0_p_q - be_sh;
    z_test      = p_neg - be_sh;
    side_in.sec = {z_test > 0, y_test > 0, s0_be_q > 0};
    side_in.ya  = YW'(s0_p_q >>> FracW) + YW'(s0_be_q >>> 1);
    side_in.za  = YW'(p_neg >>> FracW) + YW'(s0_be_q >>> 1);
    side_in.be  = s0_be_q;
  end

  // ---------------------------------------------------------------- divider
  logic             dv_v;
  logic [NumW-1:0]  factor;
  svpwm_pkg::side_t dv_side;

  svpwm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .num_i   (s0_num_q),
    .den_i   (s0_vdc_q),
    .side_i  (side_in),
    .valid_o (dv_v),
    .quo_o   (factor),
    .side_o  (dv_side)
  );

  // ---------------------------------------------------------------- back stages
  logic                    sa_v_q, sb_v_q, sc_v_q, sd_v_q;
  logic [SecW-1:0]         sa_sec_q, sb_sec_q, sc_sec_q, sd_sec_q;
  logic signed [MulW-1:0]  x_q, y_q, z_q;
  logic signed [TW-1:0]    t1_q, t2_q;
  logic signed [T0W-1:0]   t0_q, h1_q, h12_q;
  logic signed [T0W-1:0]   pa_q, pb_q, pc_q;

  logic signed [MulW-1:0]  fx, bx, yx, zx;
  logic signed [TW-1:0]    xt, yt, zt, t1_d, t2_d;
  logic signed [T0W-1:0]   base;

  always_comb begin
    fx = MulW'($signed({1'b0, factor}));
    bx = MulW'(dv_side.be);
    yx = MulW'(dv_side.ya);
    zx = MulW'(dv_side.za);
    xt = TW'(x_q);
    yt = TW'(y_q);
    zt = TW'(z_q);
    unique case (sa_sec_q)
      svpwm_pkg::SecBeta:  begin t1_d = zt;  t2_d = yt;  end
      svpwm_pkg::SecY:     begin t1_d = yt;  t2_d = -xt; end
      svpwm_pkg::SecBetaY: begin t1_d = -zt; t2_d = xt;  end
      svpwm_pkg::SecZ:     begin t1_d = -xt; t2_d = zt;  end
      svpwm_pkg::SecBetaZ: begin t1_d = xt;  t2_d = -yt; end
      svpwm_pkg::SecYZ:    begin t1_d = -yt; t2_d = -zt; end
      default:             begin t1_d = '0;  t2_d = '0;  end
    endcase
    base = T0W'($signed({1'b0, period_q, FracW'(0)}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
      sb_v_q <= 1'b0;
      sc_v_q <= 1'b0;
      sd_v_q <= 1'b0;
    end else if (en) begin
      sa_v_q <= dv_v;
      sb_v_q <= sa_v_q;
      sc_v_q <= sb_v_q;
      sd_v_q <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage A: active vector products.
      x_q      <= fx * bx;
      y_q      <= fx * yx;
      z_q      <= fx * zx;
      sa_sec_q <= dv_side.sec;
      // Stage B: pick T1 and T2 for the sector.
      t1_q     <= t1_d;
      t2_q     <= t2_d;
      sb_sec_q <= sa_sec_q;
      // Stage C: zero time and the half times.
      t0_q     <= base - T0W'(t1_q) - T0W'(t2_q);
      h1_q     <= T0W'(t1_q >>> 1);
      h12_q    <= T0W'(t1_q >>> 1) + T0W'(t2_q >>> 1);
      sc_sec_q <= sb_sec_q;
      // Stage D: the three switching points.
      pa_q     <= t0_q >>> 2;
      pb_q     <= (t0_q >>> 2) + h1_q;
      pc_q     <= (t0_q >>> 2) + h12_q;
      sd_sec_q <= sc_sec_q;
    end
  end

  // ---------------------------------------------------------------- output map
  logic [CmpW:0] sat_a, sat_b, sat_c;
  res_t          res_new;

  always_comb begin
    sat_a       = sat_cmp(pa_q);
    sat_b       = sat_cmp(pb_q);
    sat_c       = sat_cmp(pc_q);
    res_new.sec = sd_sec_q;
    res_new.clip = sat_a[CmpW] | sat_b[CmpW] | sat_c[CmpW];
    unique case (sd_sec_q)
      svpwm_pkg::SecBeta: begin
        res_new.a = sat_b[CmpW-1:0]; res_new.b = sat_a[CmpW-1:0]; res_new.c = sat_c[CmpW-1:0];
      end
      svpwm_pkg::SecY: begin
        res_new.a = sat_a[CmpW-1:0]; res_new.b = sat_c[CmpW-1:0]; res_new.c = sat_b[CmpW-1:0];
      end
      svpwm_pkg::SecBetaY: begin
        res_new.a = sat_a[CmpW-1:0]; res_new.b = sat_b[CmpW-1:0]; res_new.c = sat_c[CmpW-1:0];
      end
      svpwm_pkg::SecZ: begin
        res_new.a = sat_c[CmpW-1:0]; res_new.b = sat_b[CmpW-1:0]; res_new.c = sat_a[CmpW-1:0];
      end
      svpwm_pkg::SecBetaZ: begin
        res_new.a = sat_c[CmpW-1:0]; res_new.b = sat_a[CmpW-1:0]; res_new.c = sat_b[CmpW-1:0];
      end
      svpwm_pkg::SecYZ: begin
        res_new.a = sat_b[CmpW-1:0]; res_new.b = sat_c[CmpW-1:0]; res_new.c = sat_a[CmpW-1:0];
      end
      default: begin
        // No sector: the vector is zero and so are the compare values.
        res_new.a    = '0;
        res_new.b    = '0;
        res_new.c    = '0;
        res_new.clip = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- output and skid
  res_t out_q;
  res_t skid_q;
  logic push;
  logic take;

  assign push = en && sd_v_q;
  assign take = !out_v_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : res_new;
    end else if (push) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.cmp_phase_a = out_q.a;
  assign res_o.cmp_phase_b = out_q.b;
  assign res_o.cmp_phase_c = out_q.c;
  assign res_o.sector_code = out_q.sec;
  assign res_o.clipped     = out_q.clip;

endmodule

// File: rtl/svpwm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
// Depends on svpwm_pkg for widths and the sideband type.
`timescale 1ns / 1ps

module svpwm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [svpwm_pkg::NumW-1:0]  num_i,
  input  logic [svpwm_pkg::VdcW-1:0]  den_i,
  input  svpwm_pkg::side_t            side_i,
  output logic                        valid_o,
  output logic [svpwm_pkg::NumW-1:0]  quo_o,
  output svpwm_pkg::side_t            side_o
);

  localparam int N  = svpwm_pkg::NumW;
  localparam int DW = svpwm_pkg::VdcW;

  logic                 v_q    [N];
  logic [DW-1:0]        rem_q  [N];
  logic [DW-1:0]        den_q  [N];
  logic [N-1:0]         num_q  [N];
  logic [N-1:0]         quo_q  [N];
  svpwm_pkg::side_t     side_q [N];

  logic [DW:0]          trial  [N];
  logic                 ge     [N];
  logic [DW-1:0]        rem_d  [N];
  logic [N-1:0]         num_d  [N];
  logic [N-1:0]         quo_d  [N];

  // Each stage shifts in the next numerator bit and subtracts the divisor
  // when the partial remainder reaches it.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        trial[k] = {DW'(0), num_i[N-1]};
        ge[k]    = trial[k] >= {1'b0, den_i};
        rem_d[k] = ge[k] ? DW'(trial[k] - {1'b0, den_i}) : trial[k][DW-1:0];
        num_d[k] = num_i << 1;
        quo_d[k] = {(N-1)'(0), ge[k]};
      end else begin
        trial[k] = {rem_q[k-1], num_q[k-1][N-1]};
        ge[k]    = trial[k] >= {1'b0, den_q[k-1]};
        rem_d[k] = ge[k] ? DW'(trial[k] - {1'b0, den_q[k-1]}) : trial[k][DW-1:0];
        num_d[k] = num_q[k-1] << 1;
        quo_d[k] = {quo_q[k-1][N-2:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < N; k++) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= rem_d[k];
        num_q[k]  <= num_d[k];
        quo_q[k]  <= quo_d[k];
        den_q[k]  <= (k == 0) ? den_i  : den_q[k-1];
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// File: rtl/svpwm_checker.sv
// Port-level assertions for the SVPWM duty calculator and the bind that attaches them.
// Depends on svpwm_pkg and the top level svpwm_duty_calculator.
`timescale 1ns / 1ps

module svpwm_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic signed [svpwm_pkg::CmpW-1:0]  cmp_a_i,
  input logic signed [svpwm_pkg::CmpW-1:0]  cmp_b_i,
  input logic signed [svpwm_pkg::CmpW-1:0]  cmp_c_i,
  input logic [svpwm_pkg::SecW-1:0]         sector_i,
  input logic                               clipped_i
);

  // A result beat waits until it is taken.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled beat keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(cmp_a_i) && $stable(cmp_b_i) &&
      $stable(cmp_c_i) && $stable(sector_i) && $stable(clipped_i))
    else $error("result payload changed while stalled");

  // The three sign tests can never all pass or produce code seven.
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> sector_i != svpwm_pkg::SecInvalid)
    else $error("impossible sector code");

  // A result with no sector code gives zero compare values and no clip.
  a_sector_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && sector_i == svpwm_pkg::SecNone |->
      cmp_a_i == '0 && cmp_b_i == '0 && cmp_c_i == '0 && !clipped_i)
    else $error("nonzero result without a sector");

endmodule

bind svpwm_duty_calculator svpwm_checker u_svpwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .cmp_a_i     (res_o.cmp_phase_a),
  .cmp_b_i     (res_o.cmp_phase_b),
  .cmp_c_i     (res_o.cmp_phase_c),
  .sector_i    (res_o.sector_code),
  .clipped_i   (res_o.clipped)
);
